/* sv/sliding_window_send_limiter_core_defines.svh */
// Assertion helpers shared by the limiter modules.
// Each expects clk and rst in scope.
`ifndef SLIDING_WINDOW_SEND_LIMITER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_SEND_LIMITER_CORE_DEFINES_SVH

`define SWSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SWSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/swsl_pkg.sv */
`default_nettype none

package swsl_pkg;

  localparam int BUCKETS       = 10;
  localparam int MS_PER_BUCKET = 100;

  localparam int IN_W    = 32;
  localparam int LIMIT_W = 8;
  localparam int COUNT_W = 8;
  localparam int OUT_W   = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int TOTAL_W = $clog2(BUCKETS * 255 + 1);
  localparam int UNITS_W =
    $clog2(((64'd1 << IN_W) - 64'd1) / 64'(MS_PER_BUCKET) + 64'd1);

  // floor(x / MS_PER_BUCKET) = (x * DIV_MULT) >> DIV_SHIFT for every 32-bit x
  localparam int DIV_SHIFT = IN_W + $clog2(MS_PER_BUCKET);
  localparam int MULT_W    = IN_W + 1;
  localparam int PROD_W    = IN_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(
    ((65'd1 << DIV_SHIFT) + 65'(MS_PER_BUCKET) - 65'd1) / 65'(MS_PER_BUCKET));

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ADVANCE,
    S_SUM,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic step;
    logic accum;
    logic decide;
  } swsl_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic sum_last;
    logic out_free;
  } swsl_status_t;

endpackage

`default_nettype wire

/* sv/swsl_ctrl.sv */
`default_nettype none
`include "sliding_window_send_limiter_core_defines.svh"

module swsl_ctrl
  import swsl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire swsl_status_t status,
  output swsl_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_ADVANCE;
      end
      S_ADVANCE: begin
        if (status.steps_zero) state_next = S_SUM;
      end
      S_SUM: begin
        if (status.sum_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
      end
      S_ADVANCE: begin
        cmd.step = !status.steps_zero;
      end
      S_SUM: begin
        cmd.accum = 1'b1;
      end
      S_DECIDE: begin
        cmd.decide = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  `SWSL_ASSERT_NEXT(a_load_then_scale, cmd.load, state == S_SCALE, "load not followed by scale")

endmodule

`default_nettype wire

/* sv/swsl_dp.sv */
`default_nettype none
`include "sliding_window_send_limiter_core_defines.svh"

module swsl_dp
  import swsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [IN_W-1:0]    s_tdata,
  input  wire logic               window_limit_we,
  input  wire logic [LIMIT_W-1:0] window_limit_wdata,
  input  wire swsl_cmd_t          cmd,
  output swsl_status_t            status,
  input  wire logic               m_tready,
  output logic                    m_tvalid,
  output logic [OUT_W-1:0]        m_tdata
);

  logic [PROD_W-1:0]  prod;
  logic [UNITS_W-1:0] last_units;
  logic [LIMIT_W-1:0] limit;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   steps;
  logic [IDX_W-1:0]   idx;
  logic [TOTAL_W-1:0] total;
  logic [COUNT_W-1:0] cur_val;
  logic [COUNT_W-1:0] buckets [BUCKETS];

  logic [UNITS_W-1:0] units;
  logic [UNITS_W-1:0] diff;
  logic               back;
  logic               long_gap;
  logic [IDX_W-1:0]   cur_step;
  logic               drop_now;
  logic [COUNT_W-1:0] count_sat;
  logic               out_free;

  assign units     = prod[DIV_SHIFT +: UNITS_W];
  assign diff      = units - last_units;
  assign back      = units < last_units;
  assign long_gap  = diff >= UNITS_W'(BUCKETS);
  assign cur_step  = (cur == IDX_W'(BUCKETS - 1)) ? '0 : cur + 1'b1;
  assign drop_now  = total >= TOTAL_W'(limit);
  assign count_sat = (total > TOTAL_W'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];
  assign out_free  = !m_tvalid || m_tready;

  assign status.steps_zero = (steps == '0);
  assign status.sum_last   = (idx == IDX_W'(BUCKETS - 1));
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod <= PROD_W'(s_tdata) * PROD_W'(DIV_MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (window_limit_we) begin
      limit <= window_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_units <= '0;
      cur        <= '0;
      steps      <= '0;
      for (int i = 0; i < BUCKETS; i++) buckets[i] <= '0;
    end else begin
      if (cmd.scale) begin
        last_units <= units;
        if (back) begin
          for (int i = 0; i < BUCKETS; i++) buckets[i] <= '0;
          cur   <= '0;
          steps <= '0;
        end else if (long_gap) begin
          for (int i = 0; i < BUCKETS; i++) buckets[i] <= '0;
          steps <= '0;
        end else begin
          steps <= diff[IDX_W-1:0];
        end
      end
      if (cmd.step) begin
        cur               <= cur_step;
        buckets[cur_step] <= '0;
        steps             <= steps - 1'b1;
      end
      if (cmd.decide && !drop_now && cur_val != COUNT_MAX) begin
        buckets[cur] <= cur_val + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      idx   <= '0;
      total <= '0;
    end
    if (cmd.accum) begin
      total <= total + TOTAL_W'(buckets[idx]);
      idx   <= idx + 1'b1;
      if (idx == cur) cur_val <= buckets[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.decide) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      m_tdata <= {(OUT_W - COUNT_W - 1)'(0), count_sat, drop_now};
    end
  end

  `SWSL_ASSERT_NOW(a_decide_free, cmd.decide, out_free, "result overwrites pending transaction")
  `SWSL_ASSERT_NOW(a_step_nonzero, cmd.step, steps != '0, "advance step with no steps left")
  `SWSL_ASSERT_NOW(a_cur_range, 1'b1, cur < IDX_W'(BUCKETS), "ring index out of range")

endmodule

`default_nettype wire

/* sv/sliding_window_send_limiter_core.sv */
// Sliding-window send limiter.
// Input stream (s_tvalid/s_tready/s_tdata): one transaction per send request,
// s_tdata[31:0] = now_ms, the free-running millisecond time.
// Output stream (m_tvalid/m_tready/m_tdata): one transaction per request,
// m_tdata[0] = drop, m_tdata[8:1] = window_count (ring total before the request).
// window_limit_we/window_limit_wdata write the packet limit; change it only idle.
// Time is cut into 100 ms units over a ring of 10 bucket counters (one second).
// Each request is processed by a sequencer: a scale step divides the time by a
// reciprocal multiply, an advance step clears the buckets entered, one by one
// (0 to 9; a gap of 10 or more or a backwards step clears the ring at once),
// a sum step adds up the 10 buckets of the ring, and a decide step sets the
// result and counts the request unless it is dropped.
// s_tready is high only when idle, so one request is processed at a time.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls, the next result waits in the decide step.
// Reset (rst, synchronous) clears all buckets, the ring index and the last time
// unit, sets the limit to 50, and empties the output register.
`default_nettype none

module sliding_window_send_limiter_core
  import swsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [IN_W-1:0]    s_tdata,            // [31:0] now_ms
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OUT_W-1:0]        m_tdata,            // [0] drop, [8:1] window_count
  input  wire logic               window_limit_we,
  input  wire logic [LIMIT_W-1:0] window_limit_wdata
);

  swsl_cmd_t    cmd;
  swsl_status_t status;

  swsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swsl_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .s_tdata            (s_tdata),
    .window_limit_we    (window_limit_we),
    .window_limit_wdata (window_limit_wdata),
    .cmd                (cmd),
    .status             (status),
    .m_tready           (m_tready),
    .m_tvalid           (m_tvalid),
    .m_tdata            (m_tdata)
  );

endmodule

`default_nettype wire
